[hdl/nla_pkg.sv]
// Shared types and constants of the newline line assembler.
package nla_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_LINE  = 1'b1
    } t_op;

    // For OP_WRITE data is the character; for OP_LINE data is the line length.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       ovf;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_bstate;

endpackage

[hdl/nla_rx_if.sv]
// Input channel: one received byte per item.
interface nla_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/nla_line_if.sv]
// Output channel: one character of a completed line per item.
interface nla_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last;
    logic       empty_line;
    logic       overflow;

    modport source (output valid, output line_byte, output last, output empty_line,
                    output overflow, input ready);
    modport sink   (input valid, input line_byte, input last, input empty_line,
                    input overflow, output ready);
endinterface

[hdl/nla_queue.sv]
// Short command queue that decouples the front from the back.
module nla_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nla_pkg::t_push  i_push,
    input  logic            i_pop,
    output nla_pkg::t_cmd   o_cmd,
    output nla_pkg::t_qstat o_stat
);
    import nla_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QPW:0]     r_cnt;
    logic             do_push;

    assign o_stat.full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_mem[r_rp];
    assign do_push      = i_push.valid && !o_stat.full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/nla_front.sv]
// Front: accept bytes, track the fill count and classify each byte.
module nla_front #(
    parameter int LINE_MAX = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nla_rx_if.sink          i_rx,
    input  nla_pkg::t_qstat i_qstat,
    output nla_pkg::t_push  o_push
);
    import nla_pkg::*;

    localparam int DEPTH = LINE_MAX - 1;
    localparam int FC_W  = $clog2(LINE_MAX);

    logic [FC_W-1:0] r_fill;
    logic [FC_W-1:0] n_fill;
    logic            accept;
    logic            full;
    logic            is_lf;

    assign i_rx.ready = !i_qstat.full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign full       = (r_fill >= FC_W'(DEPTH));
    assign is_lf      = (i_rx.rx_byte == CH_LF);

    always_comb begin
        n_fill          = r_fill;
        o_push.valid    = 1'b0;
        o_push.cmd.op   = OP_WRITE;
        o_push.cmd.data = i_rx.rx_byte;
        o_push.cmd.ovf  = 1'b0;
        if (accept) begin
            if (is_lf || full) begin
                // end the line; a byte arriving on a full buffer is dropped
                o_push.valid    = 1'b1;
                o_push.cmd.op   = OP_LINE;
                o_push.cmd.data = 8'(r_fill);
                o_push.cmd.ovf  = full && !is_lf;
                n_fill          = '0;
            end else if (i_rx.rx_byte != CH_CR) begin
                o_push.valid = 1'b1;
                n_fill       = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

[hdl/nla_back.sv]
// Back: execute queued commands, hold the line store and drain completed lines.
module nla_back #(
    parameter int LINE_MAX = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nla_pkg::t_cmd   i_cmd,
    input  nla_pkg::t_qstat i_qstat,
    output logic            o_pop,
    nla_line_if.source      o_line
);
    import nla_pkg::*;

    localparam int DEPTH = LINE_MAX - 1;
    localparam int FC_W  = $clog2(LINE_MAX);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]      r_store [DEPTH];
    logic [7:0]      r_rdata;
    t_bstate         r_state;
    t_bstate         n_state;
    logic [FC_W-1:0] r_cnt;
    logic [FC_W-1:0] r_rd;
    logic [FC_W-1:0] r_wptr;
    logic            r_ovf;
    logic            r_ov;
    logic [7:0]      r_byte;
    logic            r_last;
    logic            r_empty;
    logic            r_oflag;

    logic            out_free;
    logic            mem_we;
    logic            line_pop;
    logic            load;
    logic [7:0]      ld_byte;
    logic            ld_last;
    logic            ld_empty;
    logic            ld_ovf;
    logic            cnt_zero;
    logic            rd_last;

    assign out_free = !r_ov || o_line.ready;
    assign cnt_zero = (i_cmd.data[FC_W-1:0] == '0);
    assign rd_last  = ((r_rd + 1'b1) == r_cnt);

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        line_pop = 1'b0;
        load     = 1'b0;
        ld_byte  = r_rdata;
        ld_last  = rd_last;
        ld_empty = 1'b0;
        ld_ovf   = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    unique case (i_cmd.op)
                        OP_WRITE: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_LINE: begin
                            if (cnt_zero) begin
                                // empty line: one flagged item, no store read
                                if (out_free) begin
                                    o_pop    = 1'b1;
                                    line_pop = 1'b1;
                                    load     = 1'b1;
                                    ld_byte  = CH_NUL;
                                    ld_last  = 1'b1;
                                    ld_empty = 1'b1;
                                    ld_ovf   = i_cmd.ovf;
                                end
                            end else begin
                                o_pop    = 1'b1;
                                line_pop = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = rd_last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wptr[AW-1:0]] <= i_cmd.data;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_store[r_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_wptr  <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (line_pop) begin
                r_cnt  <= i_cmd.data[FC_W-1:0];
                r_ovf  <= i_cmd.ovf;
                r_rd   <= '0;
                r_wptr <= '0;
            end
            if (mem_we) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (load && (r_state == S_SEND)) begin
                r_rd <= r_rd + 1'b1;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_line.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= ld_byte;
            r_last  <= ld_last;
            r_empty <= ld_empty;
            r_oflag <= ld_ovf;
        end
    end

    assign o_line.valid      = r_ov;
    assign o_line.line_byte  = r_byte;
    assign o_line.last       = r_last;
    assign o_line.empty_line = r_empty;
    assign o_line.overflow   = r_oflag;

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_rd < r_cnt))
        else $error("read index past line length");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_wptr < FC_W'(DEPTH)))
        else $error("store write beyond depth");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (line_pop && cnt_zero) |=> (o_line.valid && o_line.empty_line && o_line.last))
        else $error("empty line did not produce a flagged item");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_qstat.empty)
        else $error("pop from empty queue");

endmodule

[hdl/newline_line_assembler_top.sv]
// Line assembler: gather received bytes into lines and emit each completed line.
// An accepted byte passes through the command queue before the back writes it to the store;
// at a line end the back reads each stored character (S_READ), then loads it into the output
// register (S_SEND); an empty line loads one flagged item straight from idle.
// Throughput: one input byte per cycle while the queue has room; draining a line is bound
// by the single registered read port of the line store and stalls on output back-pressure.
// Reset: synchronous active low; clears fill count, queue and output valid, store is not cleared.
module newline_line_assembler_top #(
    parameter int LINE_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nla_rx_if.sink     i_rx,
    nla_line_if.source o_line
);
    import nla_pkg::*;

    t_push  push;
    t_cmd   cmd;
    t_qstat qstat;
    logic   pop;

    nla_front #(.LINE_MAX(LINE_MAX)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_qstat (qstat),
        .o_push  (push)
    );

    nla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_cmd   (cmd),
        .o_stat  (qstat)
    );

    nla_back #(.LINE_MAX(LINE_MAX)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_line  (o_line)
    );

endmodule
